// ----- sv/hrhp_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP response head parser package
// Types, constants and per-byte update functions shared by the parser modules.
// ----------------------------------------------------------------------------
package hrhp_pkg;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_C     = 8'h63;

   localparam logic [4:0] CL_LEN  = 5'd14;
   localparam logic [4:0] TE_LEN  = 5'd17;
   localparam logic [4:0] IDX_MAX = 5'd31;
   localparam logic [2:0] CK_LEN  = 3'd7;

   localparam logic [15:0] STATUS_MAX = 16'hFFFF;

   localparam int RSP_DATA_W = 88;

   typedef enum logic [1:0] {
      LINE_STATUS = 2'd0,
      LINE_NAME   = 2'd1,
      LINE_VALUE  = 2'd2
   } line_phase_type;

   typedef enum logic [1:0] {
      VAL_LEAD   = 2'd0,
      VAL_DIGITS = 2'd1,
      VAL_TRAIL  = 2'd2
   } value_phase_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_LENGTH     = 2'd1,
      ERR_NO_STATUS  = 2'd2
   } error_code_type;

   typedef struct packed {
      line_phase_type  line_phase;
      logic            pending_return;
      logic [4:0]      name_idx;
      logic            cl_out;
      logic            te_out;
      logic            name_started;
      logic            name_trailing;
      value_phase_type value_phase;
      logic [63:0]     value_acc;
      logic            value_bad;
      logic [2:0]      token_idx;
      logic            token_found;
      logic [63:0]     length_value;
      logic            length_seen;
      logic            chunked_seen;
      logic [15:0]     status_count;
      error_code_type  sticky_error;
   } hrhp_state_type;

   typedef struct packed {
      error_code_type error_code;
      logic [63:0]    body_length;
      logic           length_present;
      logic           chunked_flag;
      logic [15:0]    status_length;
   } hrhp_result_type;

   function automatic hrhp_state_type reset_state();
      hrhp_state_type s;
      s                = '0;
      s.line_phase     = LINE_STATUS;
      s.value_phase    = VAL_LEAD;
      s.sticky_error   = ERR_NONE;
      return s;
   endfunction

   function automatic hrhp_state_type clear_line(hrhp_state_type s_in);
      hrhp_state_type s;
      s               = s_in;
      s.name_idx      = '0;
      s.cl_out        = 1'b0;
      s.te_out        = 1'b0;
      s.name_started  = 1'b0;
      s.name_trailing = 1'b0;
      s.value_phase   = VAL_LEAD;
      s.value_acc     = '0;
      s.value_bad     = 1'b0;
      s.token_idx     = '0;
      s.token_found   = 1'b0;
      return s;
   endfunction

   function automatic logic [7:0] to_low(logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic logic [7:0] cl_char(logic [4:0] i);
      logic [7:0] r;
      case (i)
         5'd0:    r = "c";
         5'd1:    r = "o";
         5'd2:    r = "n";
         5'd3:    r = "t";
         5'd4:    r = "e";
         5'd5:    r = "n";
         5'd6:    r = "t";
         5'd7:    r = "-";
         5'd8:    r = "l";
         5'd9:    r = "e";
         5'd10:   r = "n";
         5'd11:   r = "g";
         5'd12:   r = "t";
         5'd13:   r = "h";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] te_char(logic [4:0] i);
      logic [7:0] r;
      case (i)
         5'd0:    r = "t";
         5'd1:    r = "r";
         5'd2:    r = "a";
         5'd3:    r = "n";
         5'd4:    r = "s";
         5'd5:    r = "f";
         5'd6:    r = "e";
         5'd7:    r = "r";
         5'd8:    r = "-";
         5'd9:    r = "e";
         5'd10:   r = "n";
         5'd11:   r = "c";
         5'd12:   r = "o";
         5'd13:   r = "d";
         5'd14:   r = "i";
         5'd15:   r = "n";
         5'd16:   r = "g";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] ck_char(logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0:    r = "c";
         3'd1:    r = "h";
         3'd2:    r = "u";
         3'd3:    r = "n";
         3'd4:    r = "k";
         3'd5:    r = "e";
         3'd6:    r = "d";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic hrhp_state_type name_byte(hrhp_state_type s_in, logic [7:0] c);
      hrhp_state_type s;
      logic           cl;
      logic           te;
      logic [7:0]     l;
      s  = s_in;
      cl = !s_in.cl_out && (s_in.name_idx == CL_LEN);
      te = !s_in.te_out && (s_in.name_idx == TE_LEN);
      l  = to_low(c);
      if (c == CHAR_COLON) begin
         s            = clear_line(s_in);
         s.cl_out     = !cl;
         s.te_out     = !te;
         s.line_phase = LINE_VALUE;
      end else if (is_blank(c)) begin
         if (s_in.name_started) begin
            s.name_trailing = 1'b1;
         end
      end else begin
         if (s_in.name_trailing) begin
            s.cl_out = 1'b1;
            s.te_out = 1'b1;
         end
         s.name_started = 1'b1;
         if (s_in.name_idx >= CL_LEN || l != cl_char(s_in.name_idx)) begin
            s.cl_out = 1'b1;
         end
         if (s_in.name_idx >= TE_LEN || l != te_char(s_in.name_idx)) begin
            s.te_out = 1'b1;
         end
         if (s_in.name_idx < IDX_MAX) begin
            s.name_idx = s_in.name_idx + 5'd1;
         end
      end
      return s;
   endfunction

   function automatic hrhp_state_type value_byte(hrhp_state_type s_in, logic [7:0] c);
      hrhp_state_type s;
      logic [7:0]     l;
      logic [67:0]    sum;
      s   = s_in;
      l   = to_low(c);
      sum = {1'b0, s_in.value_acc, 3'b000} + {3'b000, s_in.value_acc, 1'b0}
            + {64'd0, c[3:0]};
      if (!s_in.cl_out) begin
         if (is_blank(c)) begin
            if (s_in.value_phase == VAL_DIGITS) begin
               s.value_phase = VAL_TRAIL;
            end
         end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            if (s_in.value_phase == VAL_TRAIL) begin
               s.value_bad = 1'b1;
            end
            s.value_phase = VAL_DIGITS;
            if (|sum[67:64]) begin
               s.value_bad = 1'b1;
            end else begin
               s.value_acc = sum[63:0];
            end
         end else begin
            s.value_bad   = 1'b1;
            s.value_phase = VAL_DIGITS;
         end
      end else if (!s_in.te_out && !s_in.token_found) begin
         if (s_in.token_idx < CK_LEN && l == ck_char(s_in.token_idx)) begin
            s.token_idx = s_in.token_idx + 3'd1;
         end else begin
            s.token_idx = (l == CHAR_C) ? 3'd1 : 3'd0;
         end
         if (s.token_idx >= CK_LEN) begin
            s.token_found = 1'b1;
         end
      end
      return s;
   endfunction

   function automatic hrhp_state_type content_byte(hrhp_state_type s_in, logic [7:0] c);
      hrhp_state_type s;
      s = s_in;
      case (s_in.line_phase)
         LINE_STATUS: begin
            if (s_in.status_count < STATUS_MAX) begin
               s.status_count = s_in.status_count + 16'd1;
            end
         end
         LINE_NAME:  s = name_byte(s_in, c);
         LINE_VALUE: s = value_byte(s_in, c);
         default:    s = s_in;
      endcase
      return s;
   endfunction

   function automatic hrhp_state_type end_line(hrhp_state_type s_in);
      hrhp_state_type s;
      s = s_in;
      if (s_in.line_phase == LINE_VALUE) begin
         if (!s_in.cl_out) begin
            if (s_in.value_bad || s_in.value_phase == VAL_LEAD) begin
               if (s_in.sticky_error == ERR_NONE) begin
                  s.sticky_error = ERR_LENGTH;
               end
            end else begin
               s.length_value = s_in.value_acc;
               s.length_seen  = 1'b1;
            end
         end else if (!s_in.te_out && s_in.token_found) begin
            s.chunked_seen = 1'b1;
         end
      end
      s.line_phase = LINE_NAME;
      s = clear_line(s);
      return s;
   endfunction

endpackage

// ----- sv/hrhp_byte_step.sv -----
// ----------------------------------------------------------------------------
// HTTP response head parser byte step
// Computes the next parser state and the result for one request byte.
// ----------------------------------------------------------------------------
module hrhp_byte_step (
   input  hrhp_pkg::hrhp_state_type  state,
   input  logic [7:0]                data_byte,
   input  logic                      last_byte,
   output hrhp_pkg::hrhp_state_type  state_next,
   output hrhp_pkg::hrhp_result_type result
);

   hrhp_pkg::hrhp_state_type s_a;
   hrhp_pkg::hrhp_state_type s_b;
   hrhp_pkg::hrhp_state_type s_c;
   hrhp_pkg::error_code_type err;
   logic                     closed;
   logic                     is_cr;

   // A held CR is resolved first: with LF it ends the line, otherwise it is content.
   always_comb begin
      is_cr  = (data_byte == hrhp_pkg::CHAR_CR);
      closed = state.pending_return && (data_byte == hrhp_pkg::CHAR_LF);
      s_a    = state;
      s_a.pending_return = 1'b0;
      if (closed) begin
         s_a = hrhp_pkg::end_line(s_a);
      end else if (state.pending_return) begin
         s_a = hrhp_pkg::content_byte(s_a, hrhp_pkg::CHAR_CR);
      end

      s_b = s_a;
      if (!closed) begin
         if (!is_cr || last_byte) begin
            s_b = hrhp_pkg::content_byte(s_a, data_byte);
         end else begin
            s_b.pending_return = 1'b1;
         end
      end

      s_c = s_b;
      if (last_byte && !closed) begin
         s_c = hrhp_pkg::end_line(s_b);
      end

      err = s_c.sticky_error;
      if (err == hrhp_pkg::ERR_NONE && s_c.status_count == 16'd0) begin
         err = hrhp_pkg::ERR_NO_STATUS;
      end
      result            = '0;
      result.error_code = err;
      if (err == hrhp_pkg::ERR_NONE) begin
         result.body_length    = s_c.length_value;
         result.length_present = s_c.length_seen;
         result.chunked_flag   = s_c.chunked_seen;
         result.status_length  = s_c.status_count;
      end

      state_next = last_byte ? hrhp_pkg::reset_state() : s_c;
   end

endmodule

// ----- sv/http_response_head_parser_core.sv -----
// ----------------------------------------------------------------------------
// HTTP response head parser core
// Parses a response head byte stream and reports length and framing info.
// ----------------------------------------------------------------------------
// The core takes one byte of a response head per request and sustains one
// byte per clock cycle unless a last byte waits on a held result: each byte
// is registered, the parser state is updated in a single pass of logic, and
// the state register feeds the next byte. A tlast byte closes the head: it
// waits in the input byte register, then its result is registered onto the
// rsp channel and the parser state is reset so the next byte starts a new head.
// One held result and one registered byte can wait while rsp_tready is low.
module http_response_head_parser_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [7:0] data_byte
   input  logic                          req_tlast,  // last_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [1:0] error_code, [65:2] body_length, [66] length_present,
   // [67] chunked_flag, [83:68] status_length, [87:84] zero
   output logic [hrhp_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic [7:0]                in_byte_ff;
   logic [7:0]                in_byte_in;
   logic                      in_last_ff;
   logic                      in_last_in;
   hrhp_pkg::hrhp_state_type  state_ff;
   hrhp_pkg::hrhp_state_type  state_in;
   hrhp_pkg::hrhp_state_type  state_next;
   hrhp_pkg::hrhp_result_type result;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   hrhp_pkg::hrhp_result_type rsp_data_ff;
   hrhp_pkg::hrhp_result_type rsp_data_in;
   logic                      advance;
   logic                      req_fire;

   hrhp_byte_step u_step (
      .state      (state_ff),
      .data_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .state_next (state_next),
      .result     (result)
   );

   always_comb begin
      advance      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || advance;
      req_fire     = req_tvalid && req_tready;
      in_valid_in  = req_fire || (in_valid_ff && !advance);
      in_byte_in   = req_fire ? req_tdata : in_byte_ff;
      in_last_in   = req_fire ? req_tlast : in_last_ff;
      state_in     = advance ? state_next : state_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || (advance && in_last_ff);
      rsp_data_in  = (advance && in_last_ff) ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= hrhp_pkg::reset_state();
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
      in_byte_ff  <= in_byte_in;
      in_last_ff  <= in_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        rsp_data_ff.status_length,
                        rsp_data_ff.chunked_flag,
                        rsp_data_ff.length_present,
                        rsp_data_ff.body_length,
                        rsp_data_ff.error_code};

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP response head parser testbench
// Streams response heads into the parser core byte by byte and checks every
// summary it returns against a behavioral model of the parser kept here.
// Directed heads cover the length limits, both error kinds and the CR and LF
// corner cases. Random heads mix well-formed header lines with noise. Both
// channels idle at random and the result side once holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int    BYTE_GOAL   = 1550;
   localparam int    HEAD_GOAL   = 40;
   localparam int    HOLD_CYCLES = 80;
   localparam int    STALL_LIMIT = 2000;
   localparam string CL_NAME     = "content-length";
   localparam string TE_NAME     = "transfer-encoding";
   localparam string TOKEN       = "chunked";

   typedef struct {
      hrhp_pkg::error_code_type code;
      logic [63:0]              length;
      logic                     present;
      logic                     chunked;
      logic [15:0]              status;
   } head_summary_type;

   class head_checker_type;
      hrhp_pkg::line_phase_type  phase;
      bit                        cr_held;
      bit [4:0]                  name_pos;
      bit                        cl_miss;
      bit                        te_miss;
      bit                        name_begun;
      bit                        name_tail;
      hrhp_pkg::value_phase_type vphase;
      bit [63:0]                 acc;
      bit                        acc_bad;
      bit [2:0]                  tok_pos;
      bit                        tok_hit;
      bit [63:0]                 len_val;
      bit                        len_seen;
      bit                        chunk_seen;
      bit [15:0]                 status_cnt;
      hrhp_pkg::error_code_type  err;
      head_summary_type          pending_results[$];
      int                        fails;
      int                        checked;

      function new();
         fails   = 0;
         checked = 0;
         restart_head();
      endfunction

      function void drop_line();
         name_pos   = '0;
         cl_miss    = 1'b0;
         te_miss    = 1'b0;
         name_begun = 1'b0;
         name_tail  = 1'b0;
         vphase     = hrhp_pkg::VAL_LEAD;
         acc        = '0;
         acc_bad    = 1'b0;
         tok_pos    = '0;
         tok_hit    = 1'b0;
      endfunction

      function void restart_head();
         phase      = hrhp_pkg::LINE_STATUS;
         cr_held    = 1'b0;
         len_val    = '0;
         len_seen   = 1'b0;
         chunk_seen = 1'b0;
         status_cnt = '0;
         err        = hrhp_pkg::ERR_NONE;
         drop_line();
      endfunction

      function logic [7:0] fold(logic [7:0] c);
         return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
      endfunction

      function void name_char(logic [7:0] c);
         logic [7:0] lc;
         bit         cl_ok;
         bit         te_ok;
         lc = fold(c);
         if (c == hrhp_pkg::CHAR_COLON) begin
            cl_ok = !cl_miss && name_pos == 5'd14;
            te_ok = !te_miss && name_pos == 5'd17;
            drop_line();
            cl_miss = !cl_ok;
            te_miss = !te_ok;
            phase   = hrhp_pkg::LINE_VALUE;
         end else if (c == hrhp_pkg::CHAR_SPACE || c == hrhp_pkg::CHAR_TAB) begin
            if (name_begun) name_tail = 1'b1;
         end else begin
            if (name_tail) begin
               cl_miss = 1'b1;
               te_miss = 1'b1;
            end
            name_begun = 1'b1;
            if (name_pos >= 5'd14 || lc != CL_NAME[name_pos]) cl_miss = 1'b1;
            if (name_pos >= 5'd17 || lc != TE_NAME[name_pos]) te_miss = 1'b1;
            if (name_pos != 5'd31) name_pos = name_pos + 5'd1;
         end
      endfunction

      function void value_char(logic [7:0] c);
         logic [7:0] lc;
         bit [63:0]  d;
         lc = fold(c);
         if (!cl_miss) begin
            if (c == hrhp_pkg::CHAR_SPACE || c == hrhp_pkg::CHAR_TAB) begin
               if (vphase == hrhp_pkg::VAL_DIGITS) vphase = hrhp_pkg::VAL_TRAIL;
            end else if (c >= hrhp_pkg::CHAR_ZERO && c <= hrhp_pkg::CHAR_NINE) begin
               d = 64'(c - hrhp_pkg::CHAR_ZERO);
               if (vphase == hrhp_pkg::VAL_TRAIL) acc_bad = 1'b1;
               vphase = hrhp_pkg::VAL_DIGITS;
               if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) acc_bad = 1'b1;
               else acc = acc * 64'd10 + d;
            end else begin
               acc_bad = 1'b1;
               vphase  = hrhp_pkg::VAL_DIGITS;
            end
         end else if (!te_miss && !tok_hit) begin
            if (tok_pos < 3'd7 && lc == TOKEN[tok_pos]) tok_pos = tok_pos + 3'd1;
            else tok_pos = (lc == hrhp_pkg::CHAR_C) ? 3'd1 : 3'd0;
            if (tok_pos == 3'd7) tok_hit = 1'b1;
         end
      endfunction

      function void take_byte(logic [7:0] c);
         case (phase)
            hrhp_pkg::LINE_STATUS: begin
               if (status_cnt != 16'hFFFF) status_cnt = status_cnt + 16'd1;
            end
            hrhp_pkg::LINE_NAME:  name_char(c);
            hrhp_pkg::LINE_VALUE: value_char(c);
            default:              ;
         endcase
      endfunction

      function void close_line();
         if (phase == hrhp_pkg::LINE_VALUE) begin
            if (!cl_miss) begin
               if (acc_bad || vphase == hrhp_pkg::VAL_LEAD) begin
                  if (err == hrhp_pkg::ERR_NONE) err = hrhp_pkg::ERR_LENGTH;
               end else begin
                  len_val  = acc;
                  len_seen = 1'b1;
               end
            end else if (!te_miss && tok_hit) begin
               chunk_seen = 1'b1;
            end
         end
         phase = hrhp_pkg::LINE_NAME;
         drop_line();
      endfunction

      function void note_request(logic [7:0] b, logic last);
         bit               closed;
         head_summary_type r;
         closed = 1'b0;
         if (cr_held) begin
            cr_held = 1'b0;
            if (b == hrhp_pkg::CHAR_LF) begin
               close_line();
               closed = 1'b1;
            end else begin
               take_byte(hrhp_pkg::CHAR_CR);
            end
         end
         if (!closed) begin
            if (b == hrhp_pkg::CHAR_CR) cr_held = 1'b1;
            else take_byte(b);
         end
         if (!last) return;
         if (!closed) begin
            if (cr_held) begin
               cr_held = 1'b0;
               take_byte(hrhp_pkg::CHAR_CR);
            end
            close_line();
         end
         r.code = err;
         if (r.code == hrhp_pkg::ERR_NONE && status_cnt == 16'd0) begin
            r.code = hrhp_pkg::ERR_NO_STATUS;
         end
         r.length  = (r.code == hrhp_pkg::ERR_NONE) ? len_val : 64'd0;
         r.present = (r.code == hrhp_pkg::ERR_NONE) ? len_seen : 1'b0;
         r.chunked = (r.code == hrhp_pkg::ERR_NONE) ? chunk_seen : 1'b0;
         r.status  = (r.code == hrhp_pkg::ERR_NONE) ? status_cnt : 16'd0;
         pending_results.push_back(r);
         restart_head();
      endfunction

      task report(string what);
         fails++;
         $display("MISMATCH at result %0d: %s", checked, what);
      endtask

      task check_result(logic [hrhp_pkg::RSP_DATA_W-1:0] d);
         head_summary_type want;
         checked++;
         if (pending_results.size() == 0) begin
            report("result arrived with no head closed");
            return;
         end
         want = pending_results.pop_front();
         if (d[1:0] != want.code)
            report($sformatf("error_code %0d, expected %0d", d[1:0], want.code));
         if (d[65:2] != want.length)
            report($sformatf("body_length %0d, expected %0d", d[65:2], want.length));
         if (d[66] != want.present)
            report($sformatf("length_present %0d, expected %0d", d[66], want.present));
         if (d[67] != want.chunked)
            report($sformatf("chunked_flag %0d, expected %0d", d[67], want.chunked));
         if (d[83:68] != want.status)
            report($sformatf("status_length %0d, expected %0d", d[83:68], want.status));
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [7:0]                      req_tdata;
   logic                            req_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [hrhp_pkg::RSP_DATA_W-1:0] rsp_tdata;

   head_checker_type sb;
   logic [7:0]  head_bytes[$];
   bit          send_steady = 1'b0;
   bit          rsp_steady  = 1'b0;
   bit          hold_rsp    = 1'b0;
   int          bytes_sent  = 0;
   int          heads_sent  = 0;
   int          quiet_cycles = 0;

   http_response_head_parser_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no request or result moved for %0d cycles.", STALL_LIMIT);
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   initial begin : rsp_side
      int stall;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            stall    = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else begin
            if ($urandom_range(0, 15) == 0) rsp_steady = !rsp_steady;
            stall = rsp_steady ? 0 : $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         @(negedge clock);
      end
   end

   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      bytes_sent++;
   endtask

   task automatic send_head();
      for (int i = 0; i < head_bytes.size(); i++)
         send_byte(head_bytes[i], i == head_bytes.size() - 1);
      head_bytes.delete();
      heads_sent++;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic pause_until_drained();
      release_req();
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic push_text(string s, bit mix);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mix && c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'h20;
         head_bytes.push_back(c);
      end
   endtask

   task automatic push_crlf();
      head_bytes.push_back(hrhp_pkg::CHAR_CR);
      head_bytes.push_back(hrhp_pkg::CHAR_LF);
   endtask

   task automatic push_line(string s);
      push_text(s, 1'b0);
      push_crlf();
   endtask

   task automatic push_blanks(int n);
      repeat (n) begin
         head_bytes.push_back($urandom_range(0, 1) ? hrhp_pkg::CHAR_SPACE : hrhp_pkg::CHAR_TAB);
      end
   endtask

   task automatic push_digits(int n);
      repeat (n) head_bytes.push_back(hrhp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic push_noise(int n);
      repeat (n) head_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic push_printable(int n);
      repeat (n) head_bytes.push_back(8'($urandom_range(32, 126)));
   endtask

   task automatic push_length_value();
      case ($urandom_range(0, 9))
         0:       push_digits($urandom_range(6, 19));
         1:       push_text("18446744073709551615", 1'b0);
         2:       push_text("18446744073709551616", 1'b0);
         3:       push_digits($urandom_range(20, 24));
         4:       ;
         5: begin
            push_digits($urandom_range(1, 3));
            push_blanks(1);
            push_digits(1);
         end
         6: begin
            push_digits($urandom_range(1, 3));
            push_noise(1);
         end
         default: push_digits($urandom_range(1, 5));
      endcase
   endtask

   task automatic push_coding_value();
      case ($urandom_range(0, 7))
         0:       push_text("chunked", 1'b1);
         1:       push_text("gzip, chunked", 1'b1);
         2:       push_text("chunke", 1'b1);
         3:       push_text("chunchunked", 1'b1);
         4:       push_text("xchunkedy", 1'b1);
         5:       push_text("identity", 1'b1);
         6:       push_noise($urandom_range(1, 10));
         default: push_text("cchunked", 1'b1);
      endcase
   endtask

   task automatic build_random_head();
      int lines;
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 2))
            0:       push_crlf();
            1:       push_noise(1);
            default: head_bytes.push_back(hrhp_pkg::CHAR_CR);
         endcase
         return;
      end
      if ($urandom_range(0, 9) != 0) push_printable($urandom_range(1, 16));
      if ($urandom_range(0, 7) == 0) push_noise($urandom_range(1, 4));
      push_crlf();
      lines = $urandom_range(0, 3);
      repeat (lines) begin
         push_blanks(int'($urandom_range(0, 3) == 0));
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               push_text("content-length", 1'b1);
               push_blanks($urandom_range(0, 1));
               head_bytes.push_back(hrhp_pkg::CHAR_COLON);
               push_blanks($urandom_range(0, 2));
               push_length_value();
               push_blanks($urandom_range(0, 1));
            end
            3, 4: begin
               push_text("transfer-encoding", 1'b1);
               head_bytes.push_back(hrhp_pkg::CHAR_COLON);
               push_blanks($urandom_range(0, 2));
               push_coding_value();
            end
            5: begin
               case ($urandom_range(0, 3))
                  0:       push_text("content-lengthx", 1'b1);
                  1:       push_text("content-lengt", 1'b1);
                  2:       push_text("content len", 1'b1);
                  default: push_text("transfer-encodin", 1'b1);
               endcase
               head_bytes.push_back(hrhp_pkg::CHAR_COLON);
               push_digits($urandom_range(0, 3));
            end
            6: begin
               push_text("x-info", 1'b1);
               head_bytes.push_back(hrhp_pkg::CHAR_COLON);
               push_printable($urandom_range(0, 8));
               head_bytes.push_back(hrhp_pkg::CHAR_COLON);
            end
            7:       push_printable($urandom_range(1, 10));
            8:       push_noise($urandom_range(1, 12));
            default: ;
         endcase
         push_crlf();
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: push_crlf();
         4, 5:       ;
         6, 7: begin
            if (head_bytes.size() > 2 &&
                head_bytes[head_bytes.size() - 1] == hrhp_pkg::CHAR_LF) begin
               void'(head_bytes.pop_back());
               void'(head_bytes.pop_back());
            end
         end
         8:          head_bytes.push_back(hrhp_pkg::CHAR_CR);
         default:    push_noise(1);
      endcase
   endtask

   initial begin : main_flow
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed heads.
      push_crlf();
      send_head();
      push_line("HTTP/1.1 200 OK");
      push_line("Content-Length: 42");
      push_crlf();
      send_head();
      push_line("HTTP/1.0 204");
      push_text("content-length:18446744073709551615", 1'b0);
      send_head();
      push_line("x");
      push_line("CONTENT-LENGTH:  18446744073709551616 ");
      send_head();
      push_crlf();
      push_line("Content-Length: abc");
      send_head();
      push_line("HTTP/1.1 200 OK");
      push_text("Transfer-Encoding:", 1'b0);
      head_bytes.push_back(hrhp_pkg::CHAR_TAB);
      push_line("gzip, ChUnKeD");
      push_crlf();
      send_head();
      push_text("A", 1'b0);
      head_bytes.push_back(hrhp_pkg::CHAR_CR);
      push_line("B");
      push_line("X-Note: a:b:c");
      push_line("content-length 9");
      push_crlf();
      send_head();
      push_text("AB", 1'b0);
      head_bytes.push_back(hrhp_pkg::CHAR_CR);
      send_head();
      push_line("S");
      push_line("content-length: 5");
      push_line(" Content-Length : 7 ");
      push_line("content - length: 8");
      push_crlf();
      send_head();
      push_line("S");
      push_line("content-length:");
      send_head();
      push_line("S");
      push_line("content-length: 1 2");
      send_head();
      push_line("S");
      push_line("transfer-encoding: chunkchunked");
      push_line("transfer-encodingx: chunked");
      push_crlf();
      send_head();
      head_bytes.push_back(8'hFF);
      send_head();
      pause_until_drained();

      // The result side stalls for a long stretch while short heads keep coming.
      send_steady = 1'b1;
      hold_rsp    = 1'b1;
      repeat (12) begin
         push_printable($urandom_range(1, 3));
         send_head();
      end
      pause_until_drained();

      while (bytes_sent < BYTE_GOAL || sb.checked < HEAD_GOAL) begin
         send_steady = ($urandom_range(0, 3) == 0);
         build_random_head();
         send_head();
         if ($urandom_range(0, 19) == 0) pause_until_drained();
      end
      release_req();
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d response heads in %0d request bytes, with length limits,",
               heads_sent, bytes_sent);
      $display("both error kinds, CR and LF corner cases and a %0d-cycle result stall.",
               HOLD_CYCLES);
      if (sb.fails == 0 && sb.pending_results.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
